>>> src/rpe_pkg.sv
package rpe_pkg;

    localparam int W_CFG_IDX = 3;
    localparam int W_CNT = 5;

    localparam logic [W_CFG_IDX-1:0] CFG_FORGET    = 3'd0;
    localparam logic [W_CFG_IDX-1:0] CFG_THRESHOLD = 3'd1;
    localparam logic [W_CFG_IDX-1:0] CFG_TH_SPEED  = 3'd2;
    localparam logic [W_CFG_IDX-1:0] CFG_TH_CURR   = 3'd3;
    localparam logic [W_CFG_IDX-1:0] CFG_TH_CONST  = 3'd4;
    localparam logic [W_CFG_IDX-1:0] CFG_COV_DIAG  = 3'd5;

    localparam logic [31:0] RST_FORGET = 32'd4294537799;
    localparam logic signed [47:0] RST_THRESHOLD = 48'sd65536;
    localparam logic [62:0] RST_COV_DIAG = 63'd4294967296;
    localparam logic signed [63:0] ONE_Q32 = 64'sd4294967296;
    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
    localparam logic signed [63:0] LIM48_HI = 64'sd140737488355327;
    localparam logic signed [63:0] LIM48_LO = -64'sd140737488355328;

    typedef struct packed {
        logic start;
        logic sh32;
    } t_mul_req;

    typedef struct packed {
        logic done;
        logic signed [63:0] res;
    } t_unit_rsp;

    typedef struct packed {
        logic [3:0] cov_idx;
        logic [1:0] x_idx;
        logic [1:0] dst;
        logic is_w;
    } t_uw_map;

    typedef struct packed {
        logic [1:0] row;
        logic [1:0] col;
    } t_cell;

    function automatic logic [63:0] mag64(input logic signed [63:0] a);
        mag64 = a[63] ? (~a + 64'd1) : a;
    endfunction

    function automatic logic signed [63:0] sat_addsub(input logic signed [63:0] a,
                                                      input logic signed [63:0] b,
                                                      input logic sub);
        logic [63:0] bb;
        logic [64:0] sum;
        bb = sub ? ~b : b;
        sum = {a[63], a} + {bb[63], bb} + {64'd0, sub};
        if (sum[64] != sum[63]) begin
            sat_addsub = sum[64] ? S64_MIN : S64_MAX;
        end else begin
            sat_addsub = sum[63:0];
        end
    endfunction

    function automatic t_cell cell_map(input logic [3:0] n);
        t_cell c;
        c = '{row: 2'd0, col: 2'd0};
        unique case (n)
            4'd0: c = '{row: 2'd0, col: 2'd0};
            4'd1: c = '{row: 2'd0, col: 2'd1};
            4'd2: c = '{row: 2'd0, col: 2'd2};
            4'd3: c = '{row: 2'd1, col: 2'd0};
            4'd4: c = '{row: 2'd1, col: 2'd1};
            4'd5: c = '{row: 2'd1, col: 2'd2};
            4'd6: c = '{row: 2'd2, col: 2'd0};
            4'd7: c = '{row: 2'd2, col: 2'd1};
            4'd8: c = '{row: 2'd2, col: 2'd2};
            default: c = '{row: 2'd0, col: 2'd0};
        endcase
        cell_map = c;
    endfunction

    function automatic t_uw_map uw_map(input logic [W_CNT-1:0] n);
        t_cell c;
        t_uw_map m;
        if (n < 5'd9) begin
            c = cell_map(n[3:0]);
            m.cov_idx = n[3:0];
            m.x_idx = c.col;
            m.dst = c.row;
            m.is_w = 1'b0;
        end else begin
            c = cell_map(4'(n - 5'd9));
            m.cov_idx = 4'({2'd0, c.col} * 4'd3 + {2'd0, c.row});
            m.x_idx = c.col;
            m.dst = c.row;
            m.is_w = 1'b1;
        end
        uw_map = m;
    endfunction

endpackage

>>> src/rpe_mul.sv
module rpe_mul (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  rpe_pkg::t_mul_req        i_req,
    input  logic signed [63:0]       i_a,
    input  logic signed [63:0]       i_b,
    output rpe_pkg::t_unit_rsp       o_rsp
);

    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_MUL  = 3'd1;
    localparam logic [2:0] M_ADD  = 3'd2;
    localparam logic [2:0] M_NEG  = 3'd3;
    localparam logic [2:0] M_SH   = 3'd4;

    logic [2:0] r_st;
    logic [1:0] r_cnt;
    logic [63:0] r_ma, r_mb, r_pp;
    logic r_neg, r_sh32, r_done;
    logic [127:0] r_acc;
    logic signed [63:0] r_res;

    logic [31:0] pa, pb;
    logic [127:0] pp_sh;
    logic signed [127:0] shv;
    logic signed [63:0] n_res;

    always_comb begin
        pa = r_cnt[1] ? r_ma[63:32] : r_ma[31:0];
        pb = r_cnt[0] ? r_mb[63:32] : r_mb[31:0];
        priority if (r_cnt == 2'd0) begin
            pp_sh = {64'd0, r_pp};
        end else if (r_cnt == 2'd3) begin
            pp_sh = {r_pp, 64'd0};
        end else begin
            pp_sh = {32'd0, r_pp, 32'd0};
        end
        shv = r_sh32 ? ($signed(r_acc) >>> 32) : ($signed(r_acc) >>> 16);
        if ((&shv[127:63]) || ~(|shv[127:63])) begin
            n_res = shv[63:0];
        end else begin
            n_res = shv[127] ? rpe_pkg::S64_MIN : rpe_pkg::S64_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= M_IDLE;
            r_done <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_done <= 1'b0;
            unique case (r_st)
                M_IDLE: begin
                    if (i_req.start) begin
                        r_ma <= rpe_pkg::mag64(i_a);
                        r_mb <= rpe_pkg::mag64(i_b);
                        r_neg <= i_a[63] ^ i_b[63];
                        r_sh32 <= i_req.sh32;
                        r_acc <= '0;
                        r_cnt <= 2'd0;
                        r_st <= M_MUL;
                    end
                end
                M_MUL: begin
                    r_pp <= pa * pb;
                    r_st <= M_ADD;
                end
                M_ADD: begin
                    r_acc <= r_acc + pp_sh;
                    r_cnt <= r_cnt + 2'd1;
                    r_st <= (r_cnt == 2'd3) ? M_NEG : M_MUL;
                end
                M_NEG: begin
                    if (r_neg) begin
                        r_acc <= ~r_acc + 128'd1;
                    end
                    r_st <= M_SH;
                end
                M_SH: begin
                    r_res <= n_res;
                    r_done <= 1'b1;
                    r_st <= M_IDLE;
                end
                default: r_st <= M_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res = r_res;

endmodule

>>> src/rpe_div.sv
module rpe_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [63:0]       i_num,
    input  logic [63:0]              i_den,
    output rpe_pkg::t_unit_rsp       o_rsp
);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_RUN  = 2'd1;
    localparam logic [1:0] D_FIN  = 2'd2;

    logic [1:0] r_st;
    logic [5:0] r_cnt;
    logic [64:0] r_rem;
    logic [63:0] r_lo, r_q, r_d;
    logic r_neg, r_done;
    logic signed [63:0] r_res;

    logic [63:0] m;
    logic [64:0] rs;
    logic signed [63:0] n_res;

    always_comb begin
        m = rpe_pkg::mag64(i_num);
        rs = {r_rem[63:0], r_lo[63]};
        if (!r_neg) begin
            n_res = r_q[63] ? rpe_pkg::S64_MAX : r_q;
        end else begin
            n_res = r_q[63] ? rpe_pkg::S64_MIN : (~r_q + 64'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= D_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_st)
                D_IDLE: begin
                    if (i_start) begin
                        r_d <= i_den;
                        r_neg <= i_num[63];
                        r_cnt <= 6'd0;
                        r_rem <= {33'd0, m[63:32]};
                        r_lo <= {m[31:0], 32'd0};
                        if ({32'd0, m[63:32]} >= i_den) begin
                            r_q <= '1;
                            r_st <= D_FIN;
                        end else begin
                            r_q <= '0;
                            r_st <= D_RUN;
                        end
                    end
                end
                D_RUN: begin
                    if (rs >= {1'b0, r_d}) begin
                        r_rem <= rs - {1'b0, r_d};
                        r_q <= {r_q[62:0], 1'b1};
                    end else begin
                        r_rem <= rs;
                        r_q <= {r_q[62:0], 1'b0};
                    end
                    r_lo <= {r_lo[62:0], 1'b0};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_st <= D_FIN;
                    end
                end
                D_FIN: begin
                    r_res <= n_res;
                    r_done <= 1'b1;
                    r_st <= D_IDLE;
                end
                default: r_st <= D_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res = r_res;

endmodule

>>> src/rls_power_model_estimator_top.sv
// Three-parameter recursive least squares estimator with forgetting factor. Each beat on the
// input carries a sample or a restart and yields exactly one result beat with the prediction
// and the current coefficients. A restart, a held sample or a sample at or below the update
// threshold makes three passes through the shared multiplier before its result. A full update
// takes 39 products on the shared 64 by 64 multiplier, which works on four 32 by 32 partial
// products, and 12 quotients on the shared divider, which retires one quotient bit per cycle.
// The input stalls for the whole time an item is in work, and the next item is taken once the
// sequencer is idle, even while the last result still waits to be taken.
module rls_power_model_estimator_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_cmd,
    input  logic [46:0]          i_feat_speed,
    input  logic [46:0]          i_feat_current,
    input  logic signed [47:0]   i_feat_const,
    input  logic signed [47:0]   i_measured,
    input  logic                 i_hold,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [47:0]   o_predicted_loss,
    output logic signed [63:0]   o_coef_speed,
    output logic signed [63:0]   o_coef_current,
    output logic signed [63:0]   o_coef_constant,
    output logic                 o_updated,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    localparam logic [3:0] PH_IDLE = 4'd0;
    localparam logic [3:0] PH_UW   = 4'd1;
    localparam logic [3:0] PH_S    = 4'd2;
    localparam logic [3:0] PH_DEN  = 4'd3;
    localparam logic [3:0] PH_PRD  = 4'd4;
    localparam logic [3:0] PH_ERR  = 4'd5;
    localparam logic [3:0] PH_K    = 4'd6;
    localparam logic [3:0] PH_TH   = 4'd7;
    localparam logic [3:0] PH_CM   = 4'd8;
    localparam logic [3:0] PH_CD   = 4'd9;
    localparam logic [3:0] PH_OUT  = 4'd10;
    localparam logic [3:0] PH_FIN  = 4'd11;

    logic [31:0] r_ff;
    logic signed [47:0] r_thr;
    logic signed [63:0] r_init_th [3];
    logic [62:0] r_icd;

    logic signed [63:0] r_theta [3];
    logic signed [63:0] r_cov [9];
    logic signed [47:0] r_x [3];
    logic signed [63:0] r_u [3];
    logic signed [63:0] r_w [3];
    logic signed [63:0] r_k [3];
    logic signed [47:0] r_y;
    logic signed [63:0] r_acc, r_den, r_err, r_t;
    logic [3:0] r_ph;
    logic [rpe_pkg::W_CNT-1:0] r_cnt;
    logic r_wait, r_upd;

    logic r_ovalid, r_oupd;
    logic signed [47:0] r_opred;
    logic signed [63:0] r_oth [3];

    rpe_pkg::t_mul_req mul_req;
    rpe_pkg::t_unit_rsp mul_rsp, div_rsp;
    logic div_start;
    logic signed [63:0] mul_a, mul_b, div_num, add_a, add_b, add_res, lam, n_acc_sum;
    logic [63:0] div_den;
    logic add_sub;
    logic [3:0] cov_idx;
    logic [1:0] c2;
    logic signed [63:0] cov_rd;
    logic signed [47:0] n_pred;
    rpe_pkg::t_uw_map uwm;
    rpe_pkg::t_cell cm;
    logic in_acc, out_acc, fin_go;

    assign in_acc = i_valid && !o_stall;
    assign out_acc = r_ovalid && !i_stall;
    assign fin_go = (r_ph == PH_FIN) && (!r_ovalid || !i_stall);
    assign lam = (r_ff == 32'd0) ? rpe_pkg::ONE_Q32 : {32'd0, r_ff};
    assign c2 = r_cnt[1:0];
    assign uwm = rpe_pkg::uw_map(r_cnt);
    assign cm = rpe_pkg::cell_map(r_cnt[3:0]);
    assign cov_idx = (r_ph == PH_UW) ? uwm.cov_idx : r_cnt[3:0];
    assign cov_rd = r_cov[cov_idx];
    assign add_res = rpe_pkg::sat_addsub(add_a, add_b, add_sub);
    assign n_acc_sum = add_res;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        mul_req.sh32 = 1'b0;
        mul_req.start = 1'b0;
        div_start = 1'b0;
        div_num = '0;
        div_den = lam;
        add_a = r_acc;
        add_b = mul_rsp.res;
        add_sub = 1'b0;
        unique case (r_ph)
            PH_UW: begin
                mul_a = cov_rd;
                mul_b = 64'(r_x[uwm.x_idx]);
                add_a = uwm.is_w ? r_w[uwm.dst] : r_u[uwm.dst];
                mul_req.start = !r_wait;
            end
            PH_S: begin
                mul_a = 64'(r_x[c2]);
                mul_b = r_u[c2];
                mul_req.start = !r_wait;
            end
            PH_DEN: begin
                add_a = lam;
                add_b = r_acc;
            end
            PH_PRD: begin
                mul_a = 64'(r_x[c2]);
                mul_b = r_theta[c2];
                mul_req.start = !r_wait;
            end
            PH_ERR: begin
                add_a = {r_y, 16'd0};
                add_b = r_acc;
                add_sub = 1'b1;
            end
            PH_K: begin
                div_num = r_u[c2];
                div_den = r_den;
                div_start = !r_wait;
            end
            PH_TH: begin
                mul_a = r_k[c2];
                mul_b = r_err;
                mul_req.sh32 = 1'b1;
                add_a = r_theta[c2];
                mul_req.start = !r_wait;
            end
            PH_CM: begin
                mul_a = r_k[cm.row];
                mul_b = r_w[cm.col];
                mul_req.sh32 = 1'b1;
                add_a = cov_rd;
                add_sub = 1'b1;
                mul_req.start = !r_wait;
            end
            PH_CD: begin
                div_num = r_t;
                div_start = !r_wait;
            end
            PH_OUT: begin
                mul_a = 64'(r_x[c2]);
                mul_b = r_theta[c2];
                mul_req.sh32 = 1'b1;
                mul_req.start = !r_wait;
            end
            default: begin
            end
        endcase
        if (r_acc > rpe_pkg::LIM48_HI) begin
            n_pred = rpe_pkg::LIM48_HI[47:0];
        end else if (r_acc < rpe_pkg::LIM48_LO) begin
            n_pred = rpe_pkg::LIM48_LO[47:0];
        end else begin
            n_pred = r_acc[47:0];
        end
    end

    rpe_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_rsp   (mul_rsp)
    );

    rpe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ff <= rpe_pkg::RST_FORGET;
            r_thr <= rpe_pkg::RST_THRESHOLD;
            r_icd <= rpe_pkg::RST_COV_DIAG;
            for (int i = 0; i < 3; i++) begin
                r_init_th[i] <= '0;
                r_theta[i] <= '0;
                r_x[i] <= '0;
            end
            for (int i = 0; i < 9; i++) begin
                r_cov[i] <= (i % 4 == 0) ? rpe_pkg::ONE_Q32 : 64'sd0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rpe_pkg::CFG_FORGET:    r_ff <= i_cfg_data[31:0];
                rpe_pkg::CFG_THRESHOLD: r_thr <= i_cfg_data[47:0];
                rpe_pkg::CFG_TH_SPEED:  r_init_th[0] <= i_cfg_data;
                rpe_pkg::CFG_TH_CURR:   r_init_th[1] <= i_cfg_data;
                rpe_pkg::CFG_TH_CONST:  r_init_th[2] <= i_cfg_data;
                rpe_pkg::CFG_COV_DIAG:  r_icd <= i_cfg_data[62:0];
                default: begin
                end
            endcase
        end
        if (i_rst_n) begin
            if (in_acc) begin
                if (i_cmd) begin
                    for (int i = 0; i < 3; i++) begin
                        r_theta[i] <= r_init_th[i];
                    end
                    for (int i = 0; i < 9; i++) begin
                        r_cov[i] <= (i % 4 == 0) ? {1'b0, r_icd} : 64'sd0;
                    end
                end else if (!i_hold) begin
                    r_x[0] <= {1'b0, i_feat_speed};
                    r_x[1] <= {1'b0, i_feat_current};
                    r_x[2] <= i_feat_const;
                end
            end
            if (r_ph == PH_TH && mul_rsp.done) begin
                r_theta[c2] <= add_res;
            end
            if (r_ph == PH_CD && div_rsp.done) begin
                r_cov[r_cnt[3:0]] <= div_rsp.res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_IDLE;
            r_cnt <= '0;
            r_wait <= 1'b0;
            r_upd <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (mul_req.start || div_start) begin
                r_wait <= 1'b1;
            end
            if (mul_rsp.done || div_rsp.done) begin
                r_wait <= 1'b0;
            end
            if (out_acc) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_ph)
                PH_IDLE: begin
                    if (in_acc) begin
                        r_upd <= 1'b0;
                        r_acc <= '0;
                        r_cnt <= '0;
                        r_y <= i_measured;
                        if (!i_cmd && !i_hold && (i_measured > r_thr)) begin
                            for (int i = 0; i < 3; i++) begin
                                r_u[i] <= '0;
                                r_w[i] <= '0;
                            end
                            r_ph <= PH_UW;
                        end else begin
                            r_ph <= PH_OUT;
                        end
                    end
                end
                PH_UW: begin
                    if (mul_rsp.done) begin
                        if (uwm.is_w) begin
                            r_w[uwm.dst] <= add_res;
                        end else begin
                            r_u[uwm.dst] <= add_res;
                        end
                        if (r_cnt == 5'd17) begin
                            r_cnt <= '0;
                            r_ph <= PH_S;
                        end else begin
                            r_cnt <= r_cnt + 5'd1;
                        end
                    end
                end
                PH_S, PH_PRD, PH_OUT: begin
                    if (mul_rsp.done) begin
                        r_acc <= n_acc_sum;
                        if (r_cnt == 5'd2) begin
                            r_cnt <= '0;
                            priority if (r_ph == PH_S) begin
                                r_ph <= PH_DEN;
                            end else if (r_ph == PH_PRD) begin
                                r_ph <= PH_ERR;
                            end else begin
                                r_ph <= PH_FIN;
                            end
                        end else begin
                            r_cnt <= r_cnt + 5'd1;
                        end
                    end
                end
                PH_DEN: begin
                    r_acc <= '0;
                    r_cnt <= '0;
                    r_den <= add_res;
                    if (add_res[63] || add_res == 64'sd0) begin
                        r_ph <= PH_OUT;
                    end else begin
                        r_ph <= PH_PRD;
                    end
                end
                PH_ERR: begin
                    r_err <= add_res;
                    r_ph <= PH_K;
                end
                PH_K: begin
                    if (div_rsp.done) begin
                        r_k[c2] <= div_rsp.res;
                        if (r_cnt == 5'd2) begin
                            r_cnt <= '0;
                            r_upd <= 1'b1;
                            r_ph <= PH_TH;
                        end else begin
                            r_cnt <= r_cnt + 5'd1;
                        end
                    end
                end
                PH_TH: begin
                    if (mul_rsp.done) begin
                        if (r_cnt == 5'd2) begin
                            r_cnt <= '0;
                            r_ph <= PH_CM;
                        end else begin
                            r_cnt <= r_cnt + 5'd1;
                        end
                    end
                end
                PH_CM: begin
                    if (mul_rsp.done) begin
                        r_t <= add_res;
                        r_ph <= PH_CD;
                    end
                end
                PH_CD: begin
                    if (div_rsp.done) begin
                        if (r_cnt == 5'd8) begin
                            r_cnt <= '0;
                            r_acc <= '0;
                            r_ph <= PH_OUT;
                        end else begin
                            r_cnt <= r_cnt + 5'd1;
                            r_ph <= PH_CM;
                        end
                    end
                end
                PH_FIN: begin
                    if (fin_go) begin
                        r_ovalid <= 1'b1;
                        r_opred <= n_pred;
                        r_oupd <= r_upd;
                        for (int i = 0; i < 3; i++) begin
                            r_oth[i] <= r_theta[i];
                        end
                        r_ph <= PH_IDLE;
                    end
                end
                default: r_ph <= PH_IDLE;
            endcase
        end
    end

    assign o_stall = (r_ph != PH_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid = r_ovalid;
    assign o_predicted_loss = r_opred;
    assign o_coef_speed = r_oth[0];
    assign o_coef_current = r_oth[1];
    assign o_coef_constant = r_oth[2];
    assign o_updated = r_oupd;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_stall)
        else $error("sequencer did not leave idle after an accepted beat");

    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_req.start && div_start))
        else $error("multiplier and divider started together");

    a_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mul_rsp.done || div_rsp.done) |-> r_wait)
        else $error("arithmetic unit finished without a pending request");

    a_upd_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph == PH_TH) |-> r_upd)
        else $error("parameter update without the update flag");

endmodule
